// ===== hw/rtl/fsp_pkg.sv =====
// Shared types and constants for the format specification parser.
package fsp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned FLAG_W  = 7;
    localparam int unsigned FIELD_W = 24;
    localparam int unsigned PREC_W  = 25;
    localparam int unsigned LEN_W   = 2;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned OUT_DATA_W = 72;

    localparam logic [FIELD_W-1:0] FIELD_LIMIT_RESET = 24'd1048576;

    typedef enum logic [3:0] {
        PH_TEXT        = 4'd0,
        PH_FLAGS       = 4'd1,
        PH_WIDTH       = 4'd2,
        PH_AFTER_WIDTH = 4'd3,
        PH_DOT         = 4'd4,
        PH_PREC        = 4'd5,
        PH_LENSEL      = 4'd6,
        PH_LEN_H       = 4'd7,
        PH_LEN_L       = 4'd8,
        PH_SPEC        = 4'd9
    } phase_t;

    localparam logic [KIND_W-1:0] KIND_LITERAL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CONV    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

    localparam logic ERR_RESOURCE   = 1'b0;
    localparam logic ERR_INCOMPLETE = 1'b1;

    localparam logic [LEN_W-1:0] LEN_NONE  = 2'd0;
    localparam logic [LEN_W-1:0] LEN_CHAR  = 2'd1;
    localparam logic [LEN_W-1:0] LEN_SHORT = 2'd2;
    localparam logic [LEN_W-1:0] LEN_LONG  = 2'd3;

    localparam logic [FLAG_W-1:0] FLAG_LEFT      = 7'h01;
    localparam logic [FLAG_W-1:0] FLAG_PLUS      = 7'h02;
    localparam logic [FLAG_W-1:0] FLAG_SPACE     = 7'h04;
    localparam logic [FLAG_W-1:0] FLAG_ZERO      = 7'h08;
    localparam logic [FLAG_W-1:0] FLAG_ALT       = 7'h10;
    localparam logic [FLAG_W-1:0] FLAG_STAR_WID  = 7'h20;
    localparam logic [FLAG_W-1:0] FLAG_STAR_PREC = 7'h40;

    localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] CH_STAR    = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_HASH    = 8'h23;
    localparam logic [BYTE_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_ONE     = 8'h31;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] CH_LOW_H   = 8'h68;
    localparam logic [BYTE_W-1:0] CH_LOW_L   = 8'h6C;
    localparam logic [BYTE_W-1:0] CH_LOW_J   = 8'h6A;
    localparam logic [BYTE_W-1:0] CH_LOW_Z   = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_LOW_T   = 8'h74;
    localparam logic [BYTE_W-1:0] CH_UP_L    = 8'h4C;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  char_value;
        logic [FLAG_W-1:0]  flag_bits;
        logic [FIELD_W-1:0] field_width;
        logic [PREC_W-1:0]  field_precision;
        logic [LEN_W-1:0]   length_mod;
        logic               error_code;
        logic               last;
    } token_t;

endpackage

// ===== hw/rtl/fsp_digit_acc.sv =====
// Decimal accumulate step: value times ten plus one digit, checked against the limit.
module fsp_digit_acc
    import fsp_pkg::*;
(
    input  logic [FIELD_W-1:0] operand,
    input  logic [3:0]         digit,
    input  logic [FIELD_W-1:0] limit,
    output logic [FIELD_W-1:0] value,
    output logic               fits
);

    logic [FIELD_W+3:0] op_wide;
    logic [FIELD_W+3:0] sum;

    assign op_wide = {4'b0000, operand};
    assign sum     = (op_wide << 3) + (op_wide << 1) + {{FIELD_W{1'b0}}, digit};
    assign value   = sum[FIELD_W-1:0];
    assign fits    = (sum <= {4'b0000, limit});

endmodule

// ===== hw/rtl/fsp_parse_core.sv =====
// Parse state registers and the per-byte decision logic that forms one token.
module fsp_parse_core
    import fsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic [BYTE_W-1:0]  in_byte,
    input  logic               in_end,
    input  logic [FIELD_W-1:0] field_limit,
    output logic               tok_valid,
    output token_t             tok
);

    phase_t             phase_reg, phase_next;
    logic [FLAG_W-1:0]  flags_reg, flags_next;
    logic [FIELD_W-1:0] width_reg, width_next;
    logic [FIELD_W-1:0] pval_reg, pval_next;
    logic               ppres_reg, ppres_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               skip_reg, skip_next;

    logic [FIELD_W-1:0] acc_operand;
    logic [FIELD_W-1:0] acc_value;
    logic               acc_fits;
    logic               is_digit;
    logic               is_nonzero_digit;

    assign is_digit         = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign is_nonzero_digit = (in_byte >= CH_ONE) && (in_byte <= CH_NINE);

    always_comb
    begin
        case (phase_reg)
            PH_FLAGS: acc_operand = '0;
            PH_WIDTH: acc_operand = width_reg;
            default:  acc_operand = pval_reg;
        endcase
    end

    fsp_digit_acc u_digit_acc (
        .operand (acc_operand),
        .digit   (in_byte[3:0]),
        .limit   (field_limit),
        .value   (acc_value),
        .fits    (acc_fits)
    );

    always_comb
    begin
        logic go_after_width;
        logic go_len_spec;
        logic do_conv;
        logic do_resource;

        go_after_width = 1'b0;
        go_len_spec    = 1'b0;
        do_conv        = 1'b0;
        do_resource    = 1'b0;
        phase_next     = phase_reg;
        flags_next     = flags_reg;
        width_next     = width_reg;
        pval_next      = pval_reg;
        ppres_next     = ppres_reg;
        len_next       = len_reg;
        skip_next      = skip_reg;
        tok_valid      = 1'b0;
        tok            = '0;

        if (skip_reg)
        begin
            if (in_end)
            begin
                skip_next  = 1'b0;
                phase_next = PH_TEXT;
                flags_next = '0;
                width_next = '0;
                pval_next  = '0;
                ppres_next = 1'b0;
                len_next   = LEN_NONE;
            end
        end
        else
        begin
            unique case (phase_reg) inside
                PH_FLAGS:
                begin
                    if (in_byte == CH_MINUS)
                        flags_next = flags_reg | FLAG_LEFT;
                    else if (in_byte == CH_PLUS)
                        flags_next = flags_reg | FLAG_PLUS;
                    else if (in_byte == CH_SPACE)
                        flags_next = flags_reg | FLAG_SPACE;
                    else if (in_byte == CH_ZERO)
                        flags_next = flags_reg | FLAG_ZERO;
                    else if (in_byte == CH_HASH)
                        flags_next = flags_reg | FLAG_ALT;
                    else if (in_byte == CH_STAR)
                    begin
                        flags_next = flags_reg | FLAG_STAR_WID;
                        phase_next = PH_AFTER_WIDTH;
                    end
                    else if (is_nonzero_digit)
                    begin
                        if (!acc_fits)
                            do_resource = 1'b1;
                        else
                        begin
                            width_next = acc_value;
                            phase_next = PH_WIDTH;
                        end
                    end
                    else
                        go_after_width = 1'b1;
                end
                PH_WIDTH:
                begin
                    if (is_digit)
                    begin
                        if (!acc_fits)
                            do_resource = 1'b1;
                        else
                            width_next = acc_value;
                    end
                    else
                        go_after_width = 1'b1;
                end
                PH_AFTER_WIDTH:
                    go_after_width = 1'b1;
                PH_DOT, PH_PREC:
                begin
                    if ((phase_reg == PH_DOT) && (in_byte == CH_STAR))
                    begin
                        flags_next = flags_reg | FLAG_STAR_PREC;
                        ppres_next = 1'b0;
                        pval_next  = '0;
                        phase_next = PH_LENSEL;
                    end
                    else if (is_digit)
                    begin
                        if (!acc_fits)
                            do_resource = 1'b1;
                        else
                        begin
                            pval_next  = acc_value;
                            phase_next = PH_PREC;
                        end
                    end
                    else
                        go_len_spec = 1'b1;
                end
                PH_LENSEL:
                    go_len_spec = 1'b1;
                PH_LEN_H:
                begin
                    if (in_byte == CH_LOW_H)
                    begin
                        len_next   = LEN_CHAR;
                        phase_next = PH_SPEC;
                    end
                    else
                    begin
                        len_next = LEN_SHORT;
                        do_conv  = 1'b1;
                    end
                end
                PH_LEN_L:
                begin
                    len_next = LEN_LONG;
                    if (in_byte == CH_LOW_L)
                        phase_next = PH_SPEC;
                    else
                        do_conv = 1'b1;
                end
                PH_SPEC:
                    do_conv = 1'b1;
                default:
                begin
                    if ((in_byte == CH_PERCENT) && !in_end)
                    begin
                        flags_next = '0;
                        width_next = '0;
                        pval_next  = '0;
                        ppres_next = 1'b0;
                        len_next   = LEN_NONE;
                        phase_next = PH_FLAGS;
                    end
                    else
                    begin
                        phase_next     = PH_TEXT;
                        tok_valid      = 1'b1;
                        tok.kind       = KIND_LITERAL;
                        tok.char_value = in_byte;
                    end
                end
            endcase

            if (go_after_width)
            begin
                if (in_byte == CH_DOT)
                begin
                    ppres_next = 1'b1;
                    pval_next  = '0;
                    phase_next = PH_DOT;
                end
                else
                    go_len_spec = 1'b1;
            end

            if (go_len_spec)
            begin
                if (in_byte == CH_LOW_H)
                    phase_next = PH_LEN_H;
                else if (in_byte == CH_LOW_L)
                    phase_next = PH_LEN_L;
                else if ((in_byte == CH_LOW_J) || (in_byte == CH_LOW_Z) ||
                         (in_byte == CH_LOW_T) || (in_byte == CH_UP_L))
                begin
                    len_next   = LEN_LONG;
                    phase_next = PH_SPEC;
                end
                else
                    do_conv = 1'b1;
            end

            if (do_conv)
            begin
                tok_valid           = 1'b1;
                tok.kind            = KIND_CONV;
                tok.char_value      = in_byte;
                tok.flag_bits       = flags_next;
                tok.field_width     = width_next;
                tok.field_precision = ppres_next ? {1'b0, pval_next} : '1;
                tok.length_mod      = len_next;
            end

            if (do_resource)
            begin
                tok_valid      = 1'b1;
                tok.kind       = KIND_ERROR;
                tok.error_code = ERR_RESOURCE;
                skip_next      = 1'b1;
            end

            if (do_conv || do_resource)
            begin
                phase_next = PH_TEXT;
                flags_next = '0;
                width_next = '0;
                pval_next  = '0;
                ppres_next = 1'b0;
                len_next   = LEN_NONE;
            end

            if (in_end)
            begin
                if (!tok_valid)
                begin
                    tok_valid      = 1'b1;
                    tok            = '0;
                    tok.kind       = KIND_ERROR;
                    tok.error_code = ERR_INCOMPLETE;
                end
                tok.last   = 1'b1;
                skip_next  = 1'b0;
                phase_next = PH_TEXT;
                flags_next = '0;
                width_next = '0;
                pval_next  = '0;
                ppres_next = 1'b0;
                len_next   = LEN_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TEXT;
            flags_reg <= '0;
            width_reg <= '0;
            pval_reg  <= '0;
            ppres_reg <= 1'b0;
            len_reg   <= LEN_NONE;
            skip_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            width_reg <= width_next;
            pval_reg  <= pval_next;
            ppres_reg <= ppres_next;
            len_reg   <= len_next;
            skip_reg  <= skip_next;
        end
    end

endmodule

// ===== hw/rtl/format_spec_parser.sv =====
// Top level of the format specification parser: input register, parser and token register.
//
// The block reads a format string one byte per transaction on the s_axis channel
// (tdata holds the byte, tlast marks the final byte of the string) and writes
// tokens on the m_axis channel: a literal byte, a finished conversion or an error.
// tuser carries the token kind and tlast is set on the token caused by the final byte.
// Bytes inside a specification produce no token until its specifier byte arrives,
// unless a number exceeds the limit or the string ends. A byte is registered on
// acceptance and its token, if any, enters the output register once that register is free.
// One byte is taken every cycle unless stalled; the parse state is updated by a single pass
// of logic whose longest path is the multiply by ten and compare against the limit.
// When the receiver holds m_tready low the token stays in the output register,
// and once the input register is also full s_tready drops until the token leaves.
// Reset clears the parse state to plain text, empties both registers and sets
// the limit to 1048576. cfg_we writes cfg_wdata into the limit on any edge and
// is meant for use while no string is in flight.
module format_spec_parser
    import fsp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [FIELD_W-1:0]      cfg_wdata,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [BYTE_W-1:0]       s_axis_tdata,   // [7:0] format_byte
    input  logic                    s_axis_tlast,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,   // [7:0] char_value, [14:8] flag_bits,
                                                    // [38:15] field_width,
                                                    // [63:39] field_precision,
                                                    // [65:64] length_mod, [66] error_code,
                                                    // [71:67] zero
    output logic [KIND_W-1:0]       m_axis_tuser,   // [1:0] token_kind
    output logic                    m_axis_tlast
);

    logic [FIELD_W-1:0] limit_reg;
    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               in_end_reg;
    logic               out_valid_reg;
    token_t             out_tok_reg;
    logic               advance;
    logic               tok_valid;
    token_t             tok;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= FIELD_LIMIT_RESET;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_end_reg  <= s_axis_tlast;
        end
    end

    fsp_parse_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_byte     (in_byte_reg),
        .in_end      (in_end_reg),
        .field_limit (limit_reg),
        .tok_valid   (tok_valid),
        .tok         (tok)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= tok_valid;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && tok_valid)
            out_tok_reg <= tok;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_tok_reg.kind;
    assign m_axis_tlast  = out_tok_reg.last;
    assign m_axis_tdata  = {5'b00000,
                            out_tok_reg.error_code,
                            out_tok_reg.length_mod,
                            out_tok_reg.field_precision,
                            out_tok_reg.field_width,
                            out_tok_reg.flag_bits,
                            out_tok_reg.char_value};

endmodule

// ===== hw/rtl/fsp_checker.sv =====
// Port-level checks for the format specification parser and their binding.
module fsp_checker
    import fsp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [KIND_W-1:0]     m_axis_tuser,
    input logic                  m_axis_tlast
);

    // A stalled token is held unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("token changed while stalled");

    // A literal token carries nothing beyond its byte.
    a_literal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_LITERAL) |-> (m_axis_tdata[71:8] == '0))
        else $error("literal token has stray fields");

    // Only error tokens carry an error code, and they carry nothing else.
    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tuser == KIND_ERROR) ||
                           (m_axis_tdata[66] == 1'b0)) &&
                          ((m_axis_tuser != KIND_ERROR) ||
                           (m_axis_tdata[65:0] == '0)))
        else $error("error code field misused");

    // An unfinished specification is only reported at the end of a string.
    a_incomplete_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_ERROR) && m_axis_tdata[66] |-> m_axis_tlast)
        else $error("incomplete specification error without end mark");

endmodule

bind format_spec_parser fsp_checker u_fsp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== test/format_token_checker.sv =====
`timescale 1ns / 1ps
// Checker for the format specification parser: predicts tokens and compares them.
module format_token_checker
    import fsp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [FIELD_W-1:0]    cfg_wdata,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,
    input  logic                  s_axis_tlast,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic [KIND_W-1:0]     m_axis_tuser,
    input  logic                  m_axis_tlast,
    output int                    fail_count,
    output int                    pending
);

    logic [FIELD_W-1:0] field_limit;
    phase_t             spec_phase;
    logic [FLAG_W-1:0]  cur_flags;
    logic [FIELD_W-1:0] cur_width;
    logic [PREC_W-1:0]  cur_prec;
    logic [LEN_W-1:0]   cur_len;
    logic               dropping;

    token_t next_tok;
    logic   next_tok_valid;
    token_t seen_token;
    token_t expected_tokens[$];
    int     token_count;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        begin
            $display("token %0d: %s is 0x%0h, expected 0x%0h",
                     token_count, what, got, want);
            fail_count++;
        end
    endtask

    task automatic clear_spec();
        begin
            cur_flags = '0;
            cur_width = '0;
            cur_prec  = '1;
            cur_len   = LEN_NONE;
        end
    endtask

    task automatic put_token(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] ch,
                             input logic [FLAG_W-1:0] flags, input logic [FIELD_W-1:0] w,
                             input logic [PREC_W-1:0] p, input logic [LEN_W-1:0] len,
                             input logic err);
        begin
            next_tok.kind            = kind;
            next_tok.char_value      = ch;
            next_tok.flag_bits       = flags;
            next_tok.field_width     = w;
            next_tok.field_precision = p;
            next_tok.length_mod      = len;
            next_tok.error_code      = err;
            next_tok.last            = 1'b0;
            next_tok_valid           = 1'b1;
        end
    endtask

    task automatic raise_resource();
        begin
            put_token(KIND_ERROR, '0, '0, '0, '0, LEN_NONE, ERR_RESOURCE);
            dropping   = 1'b1;
            spec_phase = PH_TEXT;
            clear_spec();
        end
    endtask

    task automatic emit_conversion(input logic [BYTE_W-1:0] b);
        begin
            put_token(KIND_CONV, b, cur_flags, cur_width, cur_prec, cur_len, 1'b0);
            spec_phase = PH_TEXT;
            clear_spec();
        end
    endtask

    // A digit that would carry the number above the limit ends the specification.
    task automatic add_digit(input logic [BYTE_W-1:0] b, input logic to_prec);
        logic [63:0] v;
        begin
            v = (to_prec ? 64'(cur_prec[FIELD_W-1:0]) : 64'(cur_width)) * 64'd10
                + 64'(b - CH_ZERO);
            if (v > 64'(field_limit)) begin
                raise_resource();
            end
            else if (to_prec) begin
                cur_prec   = PREC_W'(v);
                spec_phase = PH_PREC;
            end
            else begin
                cur_width  = FIELD_W'(v);
                spec_phase = PH_WIDTH;
            end
        end
    endtask

    task automatic length_or_specifier(input logic [BYTE_W-1:0] b);
        begin
            if (b == CH_LOW_H) begin
                spec_phase = PH_LEN_H;
            end
            else if (b == CH_LOW_L) begin
                spec_phase = PH_LEN_L;
            end
            else if (b == CH_LOW_J || b == CH_LOW_Z || b == CH_LOW_T || b == CH_UP_L) begin
                cur_len    = LEN_LONG;
                spec_phase = PH_SPEC;
            end
            else begin
                emit_conversion(b);
            end
        end
    endtask

    task automatic after_width(input logic [BYTE_W-1:0] b);
        begin
            if (b == CH_DOT) begin
                cur_prec   = '0;
                spec_phase = PH_DOT;
            end
            else begin
                length_or_specifier(b);
            end
        end
    endtask

    task automatic parse_format_byte(input logic [BYTE_W-1:0] b, input logic eom);
        logic is_digit;
        begin
            is_digit       = (b >= CH_ZERO) && (b <= CH_NINE);
            next_tok_valid = 1'b0;
            if (dropping) begin
                if (eom) begin
                    dropping   = 1'b0;
                    spec_phase = PH_TEXT;
                    clear_spec();
                end
            end
            else begin
                case (spec_phase)
                    PH_FLAGS: begin
                        if (b == CH_MINUS)
                            cur_flags |= FLAG_LEFT;
                        else if (b == CH_PLUS)
                            cur_flags |= FLAG_PLUS;
                        else if (b == CH_SPACE)
                            cur_flags |= FLAG_SPACE;
                        else if (b == CH_ZERO)
                            cur_flags |= FLAG_ZERO;
                        else if (b == CH_HASH)
                            cur_flags |= FLAG_ALT;
                        else if (b == CH_STAR) begin
                            cur_flags |= FLAG_STAR_WID;
                            spec_phase = PH_AFTER_WIDTH;
                        end
                        else if (b >= CH_ONE && b <= CH_NINE)
                            add_digit(b, 1'b0);
                        else
                            after_width(b);
                    end
                    PH_WIDTH: begin
                        if (is_digit)
                            add_digit(b, 1'b0);
                        else
                            after_width(b);
                    end
                    PH_AFTER_WIDTH: after_width(b);
                    PH_DOT, PH_PREC: begin
                        if (spec_phase == PH_DOT && b == CH_STAR) begin
                            cur_flags |= FLAG_STAR_PREC;
                            cur_prec   = '1;
                            spec_phase = PH_LENSEL;
                        end
                        else if (is_digit)
                            add_digit(b, 1'b1);
                        else
                            length_or_specifier(b);
                    end
                    PH_LENSEL: length_or_specifier(b);
                    PH_LEN_H: begin
                        if (b == CH_LOW_H) begin
                            cur_len    = LEN_CHAR;
                            spec_phase = PH_SPEC;
                        end
                        else begin
                            cur_len = LEN_SHORT;
                            emit_conversion(b);
                        end
                    end
                    PH_LEN_L: begin
                        cur_len = LEN_LONG;
                        if (b == CH_LOW_L)
                            spec_phase = PH_SPEC;
                        else
                            emit_conversion(b);
                    end
                    PH_SPEC: emit_conversion(b);
                    default: begin
                        if (b == CH_PERCENT && !eom) begin
                            clear_spec();
                            spec_phase = PH_FLAGS;
                        end
                        else begin
                            spec_phase = PH_TEXT;
                            put_token(KIND_LITERAL, b, '0, '0, '0, LEN_NONE, 1'b0);
                        end
                    end
                endcase
                if (eom) begin
                    if (!next_tok_valid)
                        put_token(KIND_ERROR, '0, '0, '0, '0, LEN_NONE, ERR_INCOMPLETE);
                    next_tok.last = 1'b1;
                    dropping      = 1'b0;
                    spec_phase    = PH_TEXT;
                    clear_spec();
                end
            end
        end
    endtask

    task automatic compare_token(input token_t got, input token_t want);
        begin
            if (got.kind != want.kind)
                report_mismatch("token_kind", 64'(got.kind), 64'(want.kind));
            if (got.char_value != want.char_value)
                report_mismatch("char_value", 64'(got.char_value),
                                64'(want.char_value));
            if (got.flag_bits != want.flag_bits)
                report_mismatch("flag_bits", 64'(got.flag_bits), 64'(want.flag_bits));
            if (got.field_width != want.field_width)
                report_mismatch("field_width", 64'(got.field_width),
                                64'(want.field_width));
            if (got.field_precision != want.field_precision)
                report_mismatch("field_precision", 64'(got.field_precision),
                                64'(want.field_precision));
            if (got.length_mod != want.length_mod)
                report_mismatch("length_mod", 64'(got.length_mod),
                                64'(want.length_mod));
            if (got.error_code != want.error_code)
                report_mismatch("error_code", 64'(got.error_code),
                                64'(want.error_code));
            if (got.last != want.last)
                report_mismatch("last", 64'(got.last), 64'(want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            field_limit = FIELD_LIMIT_RESET;
            spec_phase  = PH_TEXT;
            dropping    = 1'b0;
            clear_spec();
            expected_tokens.delete();
            fail_count  = 0;
            pending     = 0;
            token_count = 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen_token.kind            = m_axis_tuser;
                seen_token.char_value      = m_axis_tdata[7:0];
                seen_token.flag_bits       = m_axis_tdata[14:8];
                seen_token.field_width     = m_axis_tdata[38:15];
                seen_token.field_precision = m_axis_tdata[63:39];
                seen_token.length_mod      = m_axis_tdata[65:64];
                seen_token.error_code      = m_axis_tdata[66];
                seen_token.last            = m_axis_tlast;
                if (m_axis_tdata[71:67] != '0)
                    report_mismatch("tdata padding", 64'(m_axis_tdata[71:67]), 64'd0);
                if (expected_tokens.size() == 0)
                    report_mismatch("unexpected transaction, char_value",
                                    64'(seen_token.char_value), 64'd0);
                else
                    compare_token(seen_token, expected_tokens.pop_front());
                token_count++;
            end
            if (cfg_we)
                field_limit = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                parse_format_byte(s_axis_tdata, s_axis_tlast);
                if (next_tok_valid)
                    expected_tokens.insert(expected_tokens.size(), next_tok);
            end
            pending = expected_tokens.size();
        end
    end

endmodule

// ===== test/tb_format_spec_parser.sv =====
`timescale 1ns / 1ps
// Testbench top for the format specification parser: clock, reset, byte stimulus and verdict.
module tb_format_spec_parser;
    import fsp_pkg::*;

    localparam int ITEMS_PER_PHASE = 140;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int SETTLE_CYCLES   = 5;
    localparam int DRAIN_CYCLES    = 8;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [FIELD_W-1:0]    cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]     m_axis_tuser;
    logic                  m_axis_tlast;

    int fail_count;
    int pending;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int quiet_cycles   = 0;
    int phase_bytes;

    logic [BYTE_W-1:0] fmt_q[$];
    string conv_chars = "diouxXfFeEgGaAcspn%";
    string flag_chars = "-+ 0#";

    always #10 clk = ~clk;

    format_spec_parser u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    format_token_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    // The run is abandoned if no transaction happens on either channel for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_format_spec_parser: FAIL");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eom);
        begin
            @(negedge clk);
            while ($urandom_range(99) < src_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= b;
            s_axis_tlast  <= eom;
            do
                @(posedge clk);
            while (!s_axis_tready);
            phase_bytes++;
        end
    endtask

    task automatic send_text(input string s);
        int i;
        begin
            for (i = 0; i < s.len(); i++)
                send_byte(s[i], i == s.len() - 1);
        end
    endtask

    task automatic wait_idle();
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            wait (pending == 0);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
    endtask

    task automatic write_limit(input logic [FIELD_W-1:0] value);
        begin
            cfg_we    <= 1'b1;
            cfg_wdata <= value;
            @(negedge clk);
            cfg_we    <= 1'b0;
        end
    endtask

    function automatic int digit_count();
        return ($urandom_range(99) < 12) ? $urandom_range(9, 4) : $urandom_range(3, 1);
    endfunction

    task automatic append_fmt(input logic [BYTE_W-1:0] b);
        begin
            fmt_q.insert(fmt_q.size(), b);
        end
    endtask

    task automatic push_digits(input int first_lo, input int count);
        int i;
        begin
            for (i = 0; i < count; i++)
                append_fmt(CH_ZERO + BYTE_W'($urandom_range(9, (i == 0) ? first_lo : 0)));
        end
    endtask

    // Mostly well-formed specifications between literal runs; some strings are cut short.
    task automatic build_random_format();
        int r;
        int keep;
        begin
            fmt_q.delete();
            repeat ($urandom_range(4, 1)) begin
                if ($urandom_range(99) < 40) begin
                    repeat ($urandom_range(3, 1))
                        append_fmt(BYTE_W'($urandom_range(255)));
                end
                else begin
                    append_fmt(CH_PERCENT);
                    repeat ($urandom_range(3, 0))
                        append_fmt(flag_chars[$urandom_range(4, 0)]);
                    r = $urandom_range(9, 0);
                    if (r >= 5)
                        push_digits(1, digit_count());
                    else if (r >= 3)
                        append_fmt(CH_STAR);
                    r = $urandom_range(9, 0);
                    if (r >= 4) begin
                        append_fmt(CH_DOT);
                        if (r == 4)
                            append_fmt(CH_STAR);
                        else if (r >= 6)
                            push_digits(0, digit_count());
                    end
                    case ($urandom_range(8, 0))
                        1: append_fmt(CH_LOW_H);
                        2: begin
                            append_fmt(CH_LOW_H);
                            append_fmt(CH_LOW_H);
                        end
                        3: append_fmt(CH_LOW_L);
                        4: begin
                            append_fmt(CH_LOW_L);
                            append_fmt(CH_LOW_L);
                        end
                        5: append_fmt(CH_LOW_J);
                        6: append_fmt(CH_LOW_Z);
                        7: append_fmt(CH_LOW_T);
                        8: append_fmt(CH_UP_L);
                        default: ;
                    endcase
                    if ($urandom_range(99) < 85)
                        append_fmt(conv_chars[$urandom_range(conv_chars.len() - 1, 0)]);
                    else
                        append_fmt(BYTE_W'($urandom_range(255)));
                end
            end
            if ($urandom_range(99) < 12) begin
                keep = $urandom_range(fmt_q.size(), 1);
                while (fmt_q.size() > keep)
                    void'(fmt_q.pop_back());
            end
        end
    endtask

    initial begin
        int p;
        int i;
        logic [FIELD_W-1:0] lim;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        phase_bytes   = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A limit of nine makes a two-digit width overflow.
        @(negedge clk);
        write_limit(24'd9);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_text("%");
        send_text("%-+ #0*.*hX");
        send_text("%*5");
        send_text("%9.0ll");
        send_text("%10x");
        send_text("%19");

        for (p = 0; p < 8; p++) begin
            wait_idle();
            case (p)
                0, 6: lim = 24'hFFFFFF;
                1, 7: lim = 24'd1;
                2: lim = FIELD_LIMIT_RESET;
                3: lim = 24'd7;
                4: lim = 24'd1000;
                default: lim = FIELD_W'($urandom_range(24'hFFFFFF, 1));
            endcase
            write_limit(lim);
            case (p % 4)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 66;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 66;
                end
                default: begin
                    src_idle_pct   = 22;
                    sink_stall_pct = 22;
                end
            endcase
            phase_bytes = 0;
            while (phase_bytes < ITEMS_PER_PHASE) begin
                build_random_format();
                for (i = 0; i < fmt_q.size(); i++)
                    send_byte(fmt_q[i], i == fmt_q.size() - 1);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_format_spec_parser: PASS");
        else
            $display("tb_format_spec_parser: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/fsp_pkg.sv
hw/rtl/fsp_digit_acc.sv
hw/rtl/fsp_parse_core.sv
hw/rtl/format_spec_parser.sv
hw/rtl/fsp_checker.sv
test/format_token_checker.sv
test/tb_format_spec_parser.sv
